>>> rtl/oss_pkg.sv
// ----------------------------------------------------------------------------
// oss_pkg
// Shared codes, types and decode functions for the operand stack shuffle unit.
// ----------------------------------------------------------------------------
package oss_pkg;

	localparam int SLOT_W  = 32;
	localparam int DEPTH_W = 7;
	localparam int NUM_LD  = 6;	// cells with a direct load port (widest shuffle)

	// request codes
	localparam logic [3:0] REQ_PUSH    = 4'd0;
	localparam logic [3:0] REQ_POP     = 4'd1;
	localparam logic [3:0] REQ_POP2    = 4'd2;
	localparam logic [3:0] REQ_DUP     = 4'd3;
	localparam logic [3:0] REQ_DUP_X1  = 4'd4;
	localparam logic [3:0] REQ_DUP_X2  = 4'd5;
	localparam logic [3:0] REQ_DUP2    = 4'd6;
	localparam logic [3:0] REQ_DUP2_X1 = 4'd7;
	localparam logic [3:0] REQ_DUP2_X2 = 4'd8;
	localparam logic [3:0] REQ_SWAP    = 4'd9;

	// status codes
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic shift_dn;	// each cell takes its upper neighbor
		logic shift_up;	// each cell takes its lower neighbor
	} cell_cmd_t;

	// slots consumed from the top
	function automatic logic [2:0] need_slots(input logic [3:0] req);
		logic [2:0] n;
		n = 3'd0;
		case (req)
			REQ_POP, REQ_DUP:                     n = 3'd1;
			REQ_POP2, REQ_DUP_X1, REQ_DUP2,
			REQ_SWAP:                             n = 3'd2;
			REQ_DUP_X2, REQ_DUP2_X1:              n = 3'd3;
			REQ_DUP2_X2:                          n = 3'd4;
			default:                              n = 3'd0;
		endcase
		return n;
	endfunction

	// growth of the stack; zero for requests that shrink it
	function automatic logic [1:0] grow_slots(input logic [3:0] req);
		logic [1:0] g;
		g = 2'd0;
		case (req)
			REQ_PUSH, REQ_DUP, REQ_DUP_X1, REQ_DUP_X2: g = 2'd1;
			REQ_DUP2, REQ_DUP2_X1, REQ_DUP2_X2:        g = 2'd2;
			default:                                   g = 2'd0;
		endcase
		return g;
	endfunction

	// set for requests that move the chain by two slots
	function automatic logic exec_extra(input logic [3:0] req);
		logic e;
		e = 1'b0;
		case (req)
			REQ_POP2, REQ_DUP2, REQ_DUP2_X1, REQ_DUP2_X2: e = 1'b1;
			default:                                      e = 1'b0;
		endcase
		return e;
	endfunction

endpackage

>>> rtl/oss_cell.sv
// ----------------------------------------------------------------------------
// oss_cell
// One stack slot: shifts toward or away from the top, or loads a new value.
// ----------------------------------------------------------------------------
module oss_cell
	import oss_pkg::*;
(
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [SLOT_W-1:0] from_above,
	input  logic [SLOT_W-1:0] from_below,
	input  logic              ld_en,
	input  logic [SLOT_W-1:0] ld_val,
	output logic [SLOT_W-1:0] slot
);

	logic [SLOT_W-1:0] slot_q;

	// load wins over the shift
	always_ff @(posedge clk) begin
		if (ld_en) begin
			slot_q <= ld_val;
		end else if (cmd.shift_dn) begin
			slot_q <= from_above;
		end else if (cmd.shift_up) begin
			slot_q <= from_below;
		end
	end

	assign slot = slot_q;

endmodule

>>> rtl/operand_stack_shuffle_unit.sv
// ----------------------------------------------------------------------------
// operand_stack_shuffle_unit
// JVM operand-stack shuffles on a chain of slot cells, cell 0 being the top.
// ----------------------------------------------------------------------------
// Refused or unknown requests pass from the input beat through ST_DONE to the
// output register; executed ones pass through ST_EXEC and then ST_DONE, and the
// chain moves one slot per cycle in ST_EXEC. Requests are taken one at a time:
// in_stall stays high until the unit is back in ST_IDLE. A finished result may
// wait in the output register while the next request is taken.
// Reset empties the stack; slot contents are not cleared.
module operand_stack_shuffle_unit
	import oss_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         req_type,
	input  logic [SLOT_W-1:0]  push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  top_slot,
	output logic [SLOT_W-1:0]  second_slot,
	output logic [DEPTH_W-1:0] depth,
	output logic [1:0]         status
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam logic [SP_W-1:0] DEPTH_MAX = SP_W'(STACK_DEPTH);

	state_t            state_q, state_d;
	logic [SP_W-1:0]   sp_q;
	logic              cnt_q;
	logic [3:0]        req_q;
	logic [1:0]        stat_q;
	logic [SLOT_W-1:0] x_q;
	logic [SLOT_W-1:0] a_q, b_q, c_q, d_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] top_q, second_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [1:0]        out_stat_q;

	logic              in_fire;
	logic              out_load;
	logic [SP_W-1:0]   need_ext, grow_ext, room;
	logic              known, refuse;
	logic [1:0]        acc_stat;
	logic              shrink, last;
	cell_cmd_t         cmd;
	logic [NUM_LD-1:0] ld_en;
	logic [SLOT_W-1:0] ld_val [NUM_LD];
	logic [SLOT_W-1:0] cell_q [STACK_DEPTH];

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;

	// admission checks against the current depth
	assign need_ext = {{(SP_W-3){1'b0}}, need_slots(req_type)};
	assign grow_ext = {{(SP_W-2){1'b0}}, grow_slots(req_type)};
	assign room     = DEPTH_MAX - sp_q;
	assign known    = (req_type <= REQ_SWAP);
	always_comb begin
		acc_stat = STAT_DONE;
		if (known && (sp_q < need_ext)) begin
			acc_stat = STAT_UNDERFLOW;
		end else if (known && (room < grow_ext)) begin
			acc_stat = STAT_OVERFLOW;
		end
	end
	assign refuse = !known || (acc_stat != STAT_DONE);

	// next state and chain command
	assign shrink = (req_q == REQ_POP) || (req_q == REQ_POP2);
	assign last   = !cnt_q;
	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		cmd.shift_dn = 1'b0;
		cmd.shift_up = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = refuse ? ST_DONE : ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.shift_up = shrink;
				cmd.shift_dn = !shrink && (grow_slots(req_q) != 2'd0);
				if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// new top arrangement, written on the last chain cycle
	always_comb begin
		for (int i = 0; i < NUM_LD; i++) begin
			ld_val[i] = a_q;
		end
		ld_en = '0;
		case (req_q)
			REQ_PUSH:    begin ld_val[0] = x_q; ld_en = 6'b000001; end
			REQ_DUP:     begin ld_en = 6'b000011; end
			REQ_DUP_X1:  begin ld_val[1] = b_q; ld_en = 6'b000111; end
			REQ_DUP_X2:  begin
				ld_val[1] = b_q; ld_val[2] = c_q; ld_en = 6'b001111;
			end
			REQ_DUP2:    begin
				ld_val[1] = b_q; ld_val[3] = b_q; ld_en = 6'b001111;
			end
			REQ_DUP2_X1: begin
				ld_val[1] = b_q; ld_val[2] = c_q; ld_val[4] = b_q;
				ld_en = 6'b011111;
			end
			REQ_DUP2_X2: begin
				ld_val[1] = b_q; ld_val[2] = c_q; ld_val[3] = d_q; ld_val[5] = b_q;
				ld_en = 6'b111111;
			end
			REQ_SWAP:    begin ld_val[0] = b_q; ld_val[1] = a_q; ld_en = 6'b000011; end
			default:     ld_en = '0;
		endcase
		if (!((state_q == ST_EXEC) && last)) begin
			ld_en = '0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			cnt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cnt_q <= exec_extra(req_type);
			end else if (state_q == ST_EXEC) begin
				cnt_q <= 1'b0;
			end
			if (cmd.shift_dn) begin
				sp_q <= sp_q + 1'b1;
			end else if (cmd.shift_up) begin
				sp_q <= sp_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= req_type;
			stat_q <= acc_stat;
			x_q    <= push_value;
			a_q    <= cell_q[0];
			b_q    <= cell_q[1];
			c_q    <= cell_q[2];
			d_q    <= cell_q[3];
		end
		if (out_load) begin
			top_q      <= (sp_q >= SP_W'(1)) ? cell_q[0] : '0;
			second_q   <= (sp_q >= SP_W'(2)) ? cell_q[1] : '0;
			depth_q    <= DEPTH_W'(sp_q);
			out_stat_q <= stat_q;
		end
	end

	// the slot chain
	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [SLOT_W-1:0] above, below;
		logic              cell_ld;
		logic [SLOT_W-1:0] cell_val;
		if (g == 0) begin : g_top
			assign above = '0;
		end else begin : g_mid
			assign above = cell_q[g-1];
		end
		if (g == STACK_DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_nxt
			assign below = cell_q[g+1];
		end
		if (g < NUM_LD) begin : g_ld
			assign cell_ld  = ld_en[g];
			assign cell_val = ld_val[g];
		end else begin : g_nold
			assign cell_ld  = 1'b0;
			assign cell_val = '0;
		end
		oss_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.from_above (above),
			.from_below (below),
			.ld_en      (cell_ld),
			.ld_val     (cell_val),
			.slot       (cell_q[g])
		);
	end

	assign out_valid   = out_valid_q;
	assign top_slot    = top_q;
	assign second_slot = second_q;
	assign depth       = depth_q;
	assign status      = out_stat_q;

endmodule

>>> rtl/oss_checker.sv
// ----------------------------------------------------------------------------
// oss_checker
// Port-level checks on the operand stack shuffle unit, attached by bind.
// ----------------------------------------------------------------------------
module oss_checker
	import oss_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [SLOT_W-1:0]  top_slot,
	input logic [SLOT_W-1:0]  second_slot,
	input logic [DEPTH_W-1:0] depth,
	input logic [1:0]         status
);

	logic               in_beat, out_beat;
	logic [1:0]         pend_q;
	logic [DEPTH_W-1:0] last_depth_q;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	// requests taken but not yet delivered, and depth of the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			last_depth_q <= '0;
		end else begin
			if (in_beat && !out_beat) begin
				pend_q <= pend_q + 1'b1;
			end else if (!in_beat && out_beat) begin
				pend_q <= pend_q - 1'b1;
			end
			if (out_beat) begin
				last_depth_q <= depth;
			end
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(top_slot)
			&& $stable(second_slot) && $stable(depth) && $stable(status))
		else $error("result changed while stalled");

	// at most one request in flight plus one result waiting
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2 && !(out_beat && pend_q == 2'd0))
		else $error("result count does not match requests");

	// absent slots read as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (STACK_DEPTH < 128) && depth < 7'd2 |->
			second_slot == '0 && (depth != 7'd0 || top_slot == '0))
		else $error("absent slot not zero");

	// a refused request leaves the depth unchanged
	a_refuse_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && (status == STAT_UNDERFLOW || status == STAT_OVERFLOW)
			|-> depth == last_depth_q)
		else $error("refused request changed the depth");

endmodule

bind operand_stack_shuffle_unit oss_checker #(.STACK_DEPTH(STACK_DEPTH)) u_oss_checker (.*);
